>>> rtl/lcc_pkg.sv
`default_nettype none

package lcc_pkg;

  // default grid size
  localparam int unsigned GRID_W_DEF = 64;
  localparam int unsigned GRID_H_DEF = 64;

  // field widths
  localparam int unsigned MM_W       = 13;
  localparam int unsigned CELL_W     = 6;
  localparam int unsigned INV_W      = 16;
  localparam int unsigned RAD_W      = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // internal arithmetic
  localparam int unsigned COORD_W = 16;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned PROD_W  = MM_W + 1 + INV_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [MM_W-1:0]    mm_t;

  // configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_INV_RES  = 2'd0;
  localparam cfg_idx_t CFG_RADIUS_X = 2'd1;
  localparam cfg_idx_t CFG_RADIUS_Y = 2'd2;

  localparam logic [INV_W-1:0] INV_RES_RST = 16'd3277;
  localparam logic [RAD_W-1:0] RADIUS_RST  = 3'd1;

  // request actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // which coordinate a conversion belongs to
  typedef logic [1:0] conv_tag_t;
  localparam conv_tag_t CONV_SX = 2'd0;
  localparam conv_tag_t CONV_SY = 2'd1;
  localparam conv_tag_t CONV_TX = 2'd2;
  localparam conv_tag_t CONV_TY = 2'd3;

  typedef struct packed {
    logic      valid;
    conv_tag_t tag;
    mm_t       mm;
  } conv_req_t;

  typedef struct packed {
    logic      valid;
    conv_tag_t tag;
    coord_t    pos;
  } conv_rsp_t;

endpackage

`default_nettype wire

>>> rtl/lcc_if.sv
`default_nettype none

interface lcc_req_if;
  import lcc_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [CELL_W-1:0] cell_x;
  logic [CELL_W-1:0] cell_y;
  logic              occupied;
  mm_t               start_x_mm;
  mm_t               start_y_mm;
  mm_t               target_x_mm;
  mm_t               target_y_mm;

  modport source (
    output valid, action, cell_x, cell_y, occupied,
    output start_x_mm, start_y_mm, target_x_mm, target_y_mm,
    input  ready
  );

  modport sink (
    input  valid, action, cell_x, cell_y, occupied,
    input  start_x_mm, start_y_mm, target_x_mm, target_y_mm,
    output ready
  );
endinterface

interface lcc_rsp_if;
  logic valid;
  logic ready;
  logic was_query;
  logic path_clear;

  modport source (output valid, was_query, path_clear, input ready);
  modport sink (input valid, was_query, path_clear, output ready);
endinterface

`default_nettype wire

>>> rtl/line_corridor_collision_check.sv
// line corridor collision check over an occupancy bitmap
//
// req_i carries one request: action 0 writes occupied into cell (cell_x, cell_y),
// action 1 traces a line between two positions in millimetres and checks the
// corridor of +-radius_x by +-radius_y cells around every point of it.
// rsp_o returns one result per request: was_query, path_clear (0 for a write).
// the user must write inverse_resolution, radius_x, radius_y via cfg while idle.
//
// the map sits in a row-wide synchronous ram, one row read per cycle.
// write: row read, row write back, result; off-grid writes skip the map.
// query: the four coordinates are scaled through one shared multiplier, then
// the line is set up; per line point the corridor window is set, each corridor
// row inside the grid is read and checked and rows outside it are skipped; a
// blocked row ends the search at once.
// one request is in work at a time; req_i.ready is high while idle.
// the result register lets a new request in while the last result waits; a
// stalled receiver holds the finished result in the done state after that.
// reset starts a clearing pass that zeroes every row; no request is taken
// until it ends; cfg writes are taken throughout, the idle rule is not enforced.
`default_nettype none

module line_corridor_collision_check #(
  parameter int unsigned GRID_W = lcc_pkg::GRID_W_DEF,
  parameter int unsigned GRID_H = lcc_pkg::GRID_H_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lcc_req_if.sink                         req_i,
  lcc_rsp_if.source                       rsp_o,
  input  logic                            cfg_we_i,
  input  logic [lcc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lcc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import lcc_pkg::*;

  localparam int unsigned RA_W  = $clog2(GRID_H);
  localparam int unsigned CA_W  = $clog2(GRID_W);
  localparam int unsigned ERR_W = COORD_W + 2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_RD,
    ST_WR_WB,
    ST_CONV,
    ST_SETUP,
    ST_POINT,
    ST_ROW_RD,
    ST_ROW_CHK,
    ST_STEP,
    ST_DONE
  } state_e;

  typedef logic signed [ERR_W-1:0] err_t;

  state_e            state_q;
  logic [RA_W-1:0]   clr_q;

  // configuration
  logic [INV_W-1:0]  inv_res_q;
  logic [RAD_W-1:0]  radius_x_q;
  logic [RAD_W-1:0]  radius_y_q;

  // latched request
  logic [CA_W-1:0]   wr_col_q;
  logic [RA_W-1:0]   wr_row_q;
  logic              wr_val_q;
  mm_t               sx_mm_q;
  mm_t               sy_mm_q;
  mm_t               tx_mm_q;
  mm_t               ty_mm_q;
  logic [2:0]        conv_k_q;

  // line walk
  coord_t            cx_q;
  coord_t            cy_q;
  coord_t            tx_q;
  coord_t            ty_q;
  coord_t            dx_q;
  coord_t            dy_q;
  logic              step_x_pos_q;
  logic              step_y_pos_q;
  err_t              err_q;
  coord_t            row_q;
  coord_t            row_end_q;
  coord_t            lo_q;
  coord_t            hi_q;

  // result
  logic              res_query_q;
  logic              res_clear_q;
  logic              rsp_valid_q;
  logic              rsp_query_q;
  logic              rsp_clear_q;
  logic              rsp_load;

  // map ram
  logic              mem_we;
  logic [RA_W-1:0]   mem_waddr;
  logic [GRID_W-1:0] mem_wdata;
  logic              mem_re;
  logic [RA_W-1:0]   mem_raddr;
  logic [GRID_W-1:0] mem_rdata;

  conv_req_t         conv_req;
  conv_rsp_t         conv_rsp;

  logic              row_in;
  logic              row_last;
  logic              at_target;
  logic              hit;
  logic              wr_in_grid;
  coord_t            dx_c;
  coord_t            dy_c;
  err_t              e2;
  logic              move_x;
  logic              move_y;

  lcc_map_mem #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lcc_mm2cell #(
    .HALF_X (GRID_W / 2),
    .HALF_Y (GRID_H / 2)
  ) u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (conv_req),
    .inv_res_i (inv_res_q),
    .rsp_o     (conv_rsp)
  );

  // feed the four coordinates into the scaler, one a cycle
  always_comb begin
    conv_req.valid = (state_q == ST_CONV) && !conv_k_q[2];
    conv_req.tag   = conv_k_q[1:0];
    case (conv_req.tag)
      CONV_SX: conv_req.mm = sx_mm_q;
      CONV_SY: conv_req.mm = sy_mm_q;
      CONV_TX: conv_req.mm = tx_mm_q;
      default: conv_req.mm = ty_mm_q;
    endcase
  end

  always_comb begin
    wr_in_grid = (32'(req_i.cell_x) < GRID_W) && (32'(req_i.cell_y) < GRID_H);
    row_in     = (row_q >= coord_t'(0)) && (row_q < coord_t'(GRID_H));
    row_last   = (row_q == row_end_q);
    at_target  = (cx_q == tx_q) && (cy_q == ty_q);

    // line setup
    dx_c = (tx_q > cx_q) ? tx_q - cx_q : cx_q - tx_q;
    dy_c = (ty_q > cy_q) ? ty_q - cy_q : cy_q - ty_q;

    // bresenham decision
    e2     = err_q <<< 1;
    move_x = e2 > -err_t'(dy_q);
    move_y = e2 < err_t'(dx_q);

    // any occupied cell of the row inside the corridor window
    hit = 1'b0;
    for (int i = 0; i < GRID_W; i++) begin
      if (mem_rdata[i] && (coord_t'(i) >= lo_q) && (coord_t'(i) <= hi_q)) begin
        hit = 1'b1;
      end
    end
  end

  // finished result moves into the result register
  assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp_o.ready);

  // ram port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = row_q[RA_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_WR_RD: begin
        mem_re    = 1'b1;
        mem_raddr = wr_row_q;
      end
      ST_WR_WB: begin
        mem_we              = 1'b1;
        mem_waddr           = wr_row_q;
        mem_wdata           = mem_rdata;
        mem_wdata[wr_col_q] = wr_val_q;
      end
      ST_ROW_RD: begin
        mem_re = row_in;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      inv_res_q    <= INV_RES_RST;
      radius_x_q   <= RADIUS_RST;
      radius_y_q   <= RADIUS_RST;
      wr_col_q     <= '0;
      wr_row_q     <= '0;
      wr_val_q     <= 1'b0;
      sx_mm_q      <= '0;
      sy_mm_q      <= '0;
      tx_mm_q      <= '0;
      ty_mm_q      <= '0;
      conv_k_q     <= '0;
      cx_q         <= '0;
      cy_q         <= '0;
      tx_q         <= '0;
      ty_q         <= '0;
      dx_q         <= '0;
      dy_q         <= '0;
      step_x_pos_q <= 1'b0;
      step_y_pos_q <= 1'b0;
      err_q        <= '0;
      row_q        <= '0;
      row_end_q    <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      res_query_q  <= 1'b0;
      res_clear_q  <= 1'b0;
      rsp_valid_q  <= 1'b0;
      rsp_query_q  <= 1'b0;
      rsp_clear_q  <= 1'b0;
    end else begin
      // configuration is taken in any state
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_INV_RES:  inv_res_q  <= cfg_data_i[INV_W-1:0];
          CFG_RADIUS_X: radius_x_q <= cfg_data_i[RAD_W-1:0];
          CFG_RADIUS_Y: radius_y_q <= cfg_data_i[RAD_W-1:0];
          default: begin
          end
        endcase
      end

      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end

      // scaled coordinates come back tagged
      if (conv_rsp.valid) begin
        case (conv_rsp.tag)
          CONV_SX: cx_q <= conv_rsp.pos;
          CONV_SY: cy_q <= conv_rsp.pos;
          CONV_TX: tx_q <= conv_rsp.pos;
          default: ty_q <= conv_rsp.pos;
        endcase
      end

      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + RA_W'(1);
          if (clr_q == RA_W'(GRID_H - 1)) begin
            state_q <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (req_i.valid) begin
            wr_col_q <= CA_W'(req_i.cell_x);
            wr_row_q <= RA_W'(req_i.cell_y);
            wr_val_q <= req_i.occupied;
            sx_mm_q  <= req_i.start_x_mm;
            sy_mm_q  <= req_i.start_y_mm;
            tx_mm_q  <= req_i.target_x_mm;
            ty_mm_q  <= req_i.target_y_mm;
            conv_k_q <= '0;
            if (req_i.action == ACT_QUERY) begin
              res_query_q <= 1'b1;
              state_q     <= ST_CONV;
            end else begin
              res_query_q <= 1'b0;
              res_clear_q <= 1'b0;
              // off-grid writes are acknowledged without touching the map
              state_q     <= wr_in_grid ? ST_WR_RD : ST_DONE;
            end
          end
        end

        ST_WR_RD: begin
          state_q <= ST_WR_WB;
        end

        ST_WR_WB: begin
          state_q <= ST_DONE;
        end

        ST_CONV: begin
          if (!conv_k_q[2]) begin
            conv_k_q <= conv_k_q + 3'd1;
          end
          if (conv_rsp.valid && conv_rsp.tag == CONV_TY) begin
            state_q <= ST_SETUP;
          end
        end

        ST_SETUP: begin
          dx_q         <= dx_c;
          dy_q         <= dy_c;
          step_x_pos_q <= cx_q < tx_q;
          step_y_pos_q <= cy_q < ty_q;
          err_q        <= err_t'(dx_c) - err_t'(dy_c);
          state_q      <= ST_POINT;
        end

        ST_POINT: begin
          row_q     <= cy_q - coord_t'(radius_y_q);
          row_end_q <= cy_q + coord_t'(radius_y_q);
          lo_q      <= cx_q - coord_t'(radius_x_q);
          hi_q      <= cx_q + coord_t'(radius_x_q);
          state_q   <= ST_ROW_RD;
        end

        ST_ROW_RD: begin
          if (row_in) begin
            state_q <= ST_ROW_CHK;
          end else if (!row_last) begin
            row_q <= row_q + coord_t'(1);
          end else if (at_target) begin
            res_clear_q <= 1'b1;
            state_q     <= ST_DONE;
          end else begin
            state_q <= ST_STEP;
          end
        end

        ST_ROW_CHK: begin
          if (hit) begin
            res_clear_q <= 1'b0;
            state_q     <= ST_DONE;
          end else if (!row_last) begin
            row_q   <= row_q + coord_t'(1);
            state_q <= ST_ROW_RD;
          end else if (at_target) begin
            res_clear_q <= 1'b1;
            state_q     <= ST_DONE;
          end else begin
            state_q <= ST_STEP;
          end
        end

        ST_STEP: begin
          err_q <= err_q - (move_x ? err_t'(dy_q) : err_t'(0))
                         + (move_y ? err_t'(dx_q) : err_t'(0));
          if (move_x) begin
            cx_q <= step_x_pos_q ? cx_q + coord_t'(1) : cx_q - coord_t'(1);
          end
          if (move_y) begin
            cy_q <= step_y_pos_q ? cy_q + coord_t'(1) : cy_q - coord_t'(1);
          end
          state_q <= ST_POINT;
        end

        ST_DONE: begin
          // hand over once the result register is free
          if (rsp_load) begin
            rsp_query_q <= res_query_q;
            rsp_clear_q <= res_clear_q;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready      = (state_q == ST_IDLE);
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.was_query  = rsp_query_q;
  assign rsp_o.path_clear = rsp_clear_q;

endmodule

`default_nettype wire

>>> rtl/lcc_map_mem.sv
`default_nettype none

module lcc_map_mem #(
  parameter  int unsigned GRID_W = lcc_pkg::GRID_W_DEF,
  parameter  int unsigned GRID_H = lcc_pkg::GRID_H_DEF,
  localparam int unsigned RA_W   = $clog2(GRID_H)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [RA_W-1:0]   waddr_i,
  input  logic [GRID_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [RA_W-1:0]   raddr_i,
  output logic [GRID_W-1:0] rdata_o
);

  // one row of the map per word
  logic [GRID_W-1:0] mem [GRID_H];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/lcc_mm2cell.sv
`default_nettype none

module lcc_mm2cell #(
  parameter int unsigned HALF_X = lcc_pkg::GRID_W_DEF / 2,
  parameter int unsigned HALF_Y = lcc_pkg::GRID_H_DEF / 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lcc_pkg::conv_req_t          req_i,
  input  logic [lcc_pkg::INV_W-1:0]   inv_res_i,
  output lcc_pkg::conv_rsp_t          rsp_o
);
  import lcc_pkg::*;

  localparam int unsigned MAG_W = MM_W + 1;

  logic signed [MAG_W-1:0] mm_ext;
  logic [MAG_W-1:0]        mag;
  logic                    s1_valid_q;
  conv_tag_t               s1_tag_q;
  logic                    s1_neg_q;
  logic [PROD_W-1:0]       s1_prod_q;
  logic [PROD_W-1:0]       rnd;
  coord_t                  cells;
  coord_t                  signed_cells;
  coord_t                  half;
  conv_rsp_t               rsp_q;

  // magnitude of the millimetre value
  always_comb begin
    mm_ext = MAG_W'(req_i.mm);
    mag    = req_i.mm[MM_W-1] ? MAG_W'(-mm_ext) : MAG_W'(mm_ext);
  end

  // round half away from zero, restore sign, offset to the grid corner
  always_comb begin
    rnd          = s1_prod_q + PROD_W'(1 << (FRAC_W - 1));
    cells        = coord_t'(rnd[PROD_W-1:FRAC_W]);
    signed_cells = s1_neg_q ? -cells : cells;
    half         = (s1_tag_q == CONV_SY || s1_tag_q == CONV_TY) ?
                   coord_t'(HALF_Y) : coord_t'(HALF_X);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_tag_q   <= CONV_SX;
      s1_neg_q   <= 1'b0;
      s1_prod_q  <= '0;
      rsp_q      <= '0;
    end else begin
      s1_valid_q  <= req_i.valid;
      s1_tag_q    <= req_i.tag;
      s1_neg_q    <= req_i.mm[MM_W-1];
      s1_prod_q   <= PROD_W'(mag) * PROD_W'(inv_res_i);
      rsp_q.valid <= s1_valid_q;
      rsp_q.tag   <= s1_tag_q;
      rsp_q.pos   <= signed_cells + half;
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

>>> rtl/lcc_checker.sv
`default_nettype none

module lcc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input logic rsp_was_query_i,
  input logic rsp_path_clear_i
);

  // requests taken but not yet answered
  logic [1:0] outst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_q + 2'(req_valid_i && req_ready_i)
                         - 2'(rsp_valid_i && rsp_ready_i);
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_was_query_i) && $stable(rsp_path_clear_i))
    else $error("result changed while stalled");

  a_no_orphan_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> outst_q != 2'd0)
    else $error("result without a pending request");

  a_two_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q == 2'd2 |-> !req_ready_i)
    else $error("request taken with two pending");

  a_write_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_was_query_i |-> !rsp_path_clear_i)
    else $error("write acknowledge reports a clear path");

endmodule

bind line_corridor_collision_check lcc_checker u_lcc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_was_query_i  (rsp_o.was_query),
  .rsp_path_clear_i (rsp_o.path_clear)
);

`default_nettype wire
